// ===== rtl/core/esl_pkg.sv =====
`timescale 1ns / 1ps
package esl_pkg;

    // layer geometry
    localparam int MaxCells = 4096;
    localparam int CellAw   = $clog2(MaxCells);
    localparam int LenW     = 13;
    localparam int CellW    = 48;
    localparam int ThrW     = 16;
    localparam int PosW     = 16;
    localparam int EnW      = 21;
    localparam int IdxW     = 13;

    // shared unit widths
    localparam int NumW  = 64;
    localparam int DenW  = 25;
    localparam int RadW  = 50;
    localparam int RootW = 25;

    // divide by three: floor(x * Recip3 / 2^Recip3Sh) is exact for x below 2^32
    localparam logic [31:0] Recip3   = 32'hAAAA_AAAB;
    localparam int          Recip3Sh = 33;
    localparam int          Div3HalfW = 25;

    // register map (byte address bit 2 selects)
    localparam logic REG_LAYER_LEN = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;

    localparam logic REQ_PARTICLE = 1'b0;
    localparam logic REQ_STORM_END = 1'b1;

    localparam logic [CellW-1:0] MINUS_ONE_Q16 = 48'hFFFF_FFFF_0000;

    typedef enum logic {
        ALU_DIV,
        ALU_SQRT
    } t_alu_op;

    typedef struct packed {
        logic            go;
        t_alu_op         op;
        logic [NumW-1:0] num;
        logic [DenW-1:0] den;
        logic [RadW-1:0] rad;
    } t_alu_req;

    typedef struct packed {
        logic             done;
        logic [NumW-1:0]  quo;
        logic [RootW-1:0] root;
    } t_alu_rsp;

endpackage

// ===== rtl/core/energy_storm_layer_sim.sv =====
`timescale 1ns / 1ps
// 1-D energy layer hit by particle storms, cells in signed Q32.16, saturating.
// Items: raise start with i_req_type/i_position/i_energy_value while busy is low;
// the item is taken at that edge and busy stays high until it is finished.
// A particle item (i_req_type 0) adds its contribution to each cell in use where it
// passes the threshold, and gives no result. The item runs the scale divide,
// then per cell an issue step, a square root and a divide in the one shared
// divide/root unit.
// An end-of-storm item relaxes the layer with a 3-point average and reports the
// largest cell above -1.0 and its first index (else -1.0 and index -1) on
// o_max_value/o_max_position, marked by o_valid for one cycle in the first cycle
// with busy low; the /3 is two reciprocal multiplies, in S_R_DIVH and S_R_DIVL.
// One item finishes before the next is taken. The receiver cannot stall; the
// result must be taken in the cycle it is shown.
// Cells live in one single-port-write, registered-read memory of 4096 words.
// After reset the block clears all 4096 cells, one cell a cycle, with busy high.
// The APB registers (layer_len at 0x0, threshold at 0x4) reset to 4096 and 66;
// the user must write them only while busy is low; the block does not check.
module energy_storm_layer_sim (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_req_type,
    input  logic [esl_pkg::PosW-1:0]   i_position,
    input  logic signed [esl_pkg::EnW-1:0] i_energy_value,
    output logic                       o_valid,
    output logic signed [esl_pkg::CellW-1:0] o_max_value,
    output logic signed [esl_pkg::IdxW-1:0]  o_max_position,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_P_SCALE,
        S_P_SCALEW,
        S_P_CELL,
        S_P_SQRTW,
        S_P_DIVW,
        S_R_LOAD0,
        S_R_LOAD1,
        S_R_NEXT0,
        S_R_NEXT1,
        S_R_DIVH,
        S_R_DIVL
    } t_state;

    localparam int CW = esl_pkg::CellW;
    localparam int AW = esl_pkg::CellAw;
    localparam int HW = esl_pkg::Div3HalfW;

    t_state r_state;
    logic [esl_pkg::LenW-1:0]  r_len;
    logic [esl_pkg::ThrW-1:0]  r_thr;
    logic [esl_pkg::LenW-1:0]  r_k;
    logic [AW-1:0]             r_raddr;
    logic                      r_neg;
    logic [esl_pkg::PosW-1:0]  r_pos;
    logic [30:0]               r_prod;
    logic [46:0]               r_m;
    logic signed [CW-1:0]      r_left;
    logic signed [CW-1:0]      r_cur;
    logic signed [CW-1:0]      r_right;
    logic                      r_sneg;
    logic [CW+1:0]             r_mag3;
    logic [HW-1:0]             r_qh;
    logic [1:0]                r_rh;
    logic signed [CW-1:0]      r_max;
    logic [esl_pkg::IdxW-1:0]  r_maxi;
    logic                      r_valid;
    logic signed [CW-1:0]      r_out_max;
    logic [esl_pkg::IdxW-1:0]  r_out_idx;

    esl_pkg::t_alu_req alu_req;
    esl_pkg::t_alu_rsp alu_rsp;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [CW-1:0]     ram_wdata;
    logic signed [CW-1:0] ram_rdata;

    logic [esl_pkg::LenW-1:0] n_cells;
    logic                     last_k;
    logic [esl_pkg::EnW-1:0]  en_mag;
    logic [16:0]              dist_p1;
    logic [46:0]              q_val;
    logic                     q_pass;
    logic [28:0]              q_prod;
    logic signed [CW:0]       p_sum;
    logic signed [CW-1:0]     p_cell;
    logic signed [CW-1:0]     right_val;
    logic signed [CW+1:0]     sum3;
    logic [CW+1:0]            mag3;
    logic [HW+1:0]            div_in;
    logic [57:0]              div_prod;
    logic [HW-1:0]            div_q;
    logic [1:0]               div_rem;
    logic [CW+1:0]            quo3;
    logic signed [CW-1:0]     relax_val;

    // cells in use, clamped to 1..MaxCells
    always_comb begin
        if (r_len == '0) begin
            n_cells = esl_pkg::LenW'(1);
        end else if (r_len > esl_pkg::LenW'(esl_pkg::MaxCells)) begin
            n_cells = esl_pkg::LenW'(esl_pkg::MaxCells);
        end else begin
            n_cells = r_len;
        end
    end
    assign last_k = (r_k + esl_pkg::LenW'(1)) == n_cells;

    assign en_mag = i_energy_value[esl_pkg::EnW-1] ? (~i_energy_value + esl_pkg::EnW'(1))
                                                   : i_energy_value;

    // distance to impact plus one
    always_comb begin
        if (r_pos >= esl_pkg::PosW'(r_k)) begin
            dist_p1 = {1'b0, r_pos - esl_pkg::PosW'(r_k)} + 17'd1;
        end else begin
            dist_p1 = {1'b0, esl_pkg::PosW'(r_k) - r_pos} + 17'd1;
        end
    end

    // contribution, threshold test, saturating add
    always_comb begin
        q_val  = alu_rsp.quo[46:0];
        q_prod = 29'(q_val[15:0]) * 29'(n_cells);
        q_pass = (|q_val[46:16]) || (q_prod >= 29'(r_thr));
        if (r_neg) begin
            p_sum = {ram_rdata[CW-1], ram_rdata} - {2'b00, q_val};
        end else begin
            p_sum = {ram_rdata[CW-1], ram_rdata} + {2'b00, q_val};
        end
        if (p_sum[CW] != p_sum[CW-1]) begin
            p_cell = p_sum[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
        end else begin
            p_cell = p_sum[CW-1:0];
        end
    end

    // 3-point sum and its magnitude; the last cell is its own right neighbor
    always_comb begin
        right_val = last_k ? r_cur : ram_rdata;
        sum3 = {{2{r_left[CW-1]}}, r_left} + {{2{r_cur[CW-1]}}, r_cur}
             + {{2{right_val[CW-1]}}, right_val};
        mag3 = sum3[CW+1] ? (~sum3 + (CW+2)'(1)) : sum3;
    end

    // divide by three in two 25-bit halves, one reciprocal multiply each
    always_comb begin
        if (r_state == S_R_DIVH) begin
            div_in = {2'b00, r_mag3[CW+1:HW]};
        end else begin
            div_in = {r_rh, r_mag3[HW-1:0]};
        end
        div_prod  = 58'(div_in) * 58'(esl_pkg::Recip3);
        div_q     = div_prod[esl_pkg::Recip3Sh +: HW];
        div_rem   = div_in[1:0] - div_q[1:0] - {div_q[0], 1'b0};
        quo3      = {r_qh, div_q};
        relax_val = r_sneg ? (~quo3[CW-1:0] + CW'(1)) : quo3[CW-1:0];
    end

    // shared unit requests
    always_comb begin
        alu_req     = '0;
        alu_req.op  = esl_pkg::ALU_DIV;
        unique case (r_state)
            S_P_SCALE: begin
                alu_req.go  = 1'b1;
                alu_req.num = {17'd0, r_prod, 16'd0};
                alu_req.den = esl_pkg::DenW'(n_cells);
            end
            S_P_CELL: begin
                alu_req.go  = 1'b1;
                alu_req.op  = esl_pkg::ALU_SQRT;
                alu_req.rad = {1'b0, dist_p1, 32'd0};
            end
            S_P_SQRTW: begin
                alu_req.go  = alu_rsp.done;
                alu_req.num = {1'b0, r_m, 16'd0};
                alu_req.den = alu_rsp.root;
            end
            default: ;
        endcase
    end

    // cell memory writes
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_k[AW-1:0];
        ram_wdata = '0;
        unique case (r_state)
            S_CLEAR: ram_we = 1'b1;
            S_P_DIVW: begin
                ram_we    = alu_rsp.done && q_pass;
                ram_wdata = p_cell;
            end
            S_R_DIVL: begin
                ram_we    = 1'b1;
                ram_wdata = relax_val;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_k <= r_k + esl_pkg::LenW'(1);
                    if (r_k == esl_pkg::LenW'(esl_pkg::MaxCells - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_k     <= '0;
                    r_raddr <= '0;
                    if (start) begin
                        r_pos  <= i_position;
                        r_neg  <= i_energy_value[esl_pkg::EnW-1];
                        r_prod <= 31'(en_mag) * 31'd1000;
                        r_max  <= esl_pkg::MINUS_ONE_Q16;
                        r_maxi <= '1;
                        if (i_req_type == esl_pkg::REQ_PARTICLE) begin
                            r_state <= S_P_SCALE;
                        end else begin
                            r_state <= S_R_LOAD0;
                        end
                    end
                end
                S_P_SCALE: r_state <= S_P_SCALEW;
                S_P_SCALEW: begin
                    if (alu_rsp.done) begin
                        r_m     <= alu_rsp.quo[46:0];
                        r_state <= S_P_CELL;
                    end
                end
                S_P_CELL: r_state <= S_P_SQRTW;
                S_P_SQRTW: begin
                    if (alu_rsp.done) begin
                        r_state <= S_P_DIVW;
                    end
                end
                S_P_DIVW: begin
                    if (alu_rsp.done) begin
                        if (last_k) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + esl_pkg::LenW'(1);
                            r_raddr <= AW'(r_k + esl_pkg::LenW'(1));
                            r_state <= S_P_CELL;
                        end
                    end
                end
                S_R_LOAD0: r_state <= S_R_LOAD1;
                S_R_LOAD1: begin
                    r_left  <= ram_rdata;
                    r_cur   <= ram_rdata;
                    r_raddr <= AW'(1);
                    r_state <= S_R_NEXT0;
                end
                S_R_NEXT0: r_state <= S_R_NEXT1;
                S_R_NEXT1: begin
                    r_mag3  <= mag3;
                    r_sneg  <= sum3[CW+1];
                    r_state <= S_R_DIVH;
                end
                S_R_DIVH: begin
                    r_qh    <= div_q;
                    r_rh    <= div_rem;
                    r_state <= S_R_DIVL;
                end
                S_R_DIVL: begin
                    r_left <= r_cur;
                    r_cur  <= r_right;
                    if (relax_val > r_max) begin
                        r_max  <= relax_val;
                        r_maxi <= r_k;
                    end
                    if (last_k) begin
                        r_valid   <= 1'b1;
                        r_out_max <= (relax_val > r_max) ? relax_val : r_max;
                        r_out_idx <= (relax_val > r_max) ? r_k : r_maxi;
                        r_state   <= S_IDLE;
                    end else begin
                        r_k     <= r_k + esl_pkg::LenW'(1);
                        r_raddr <= AW'(r_k + esl_pkg::LenW'(2));
                        r_state <= S_R_NEXT0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // right neighbor: next cell, or the cell itself at the edge
    always_ff @(posedge i_clk) begin
        if (r_state == S_R_NEXT1) begin
            r_right <= right_val;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= esl_pkg::LenW'(esl_pkg::MaxCells);
            r_thr <= esl_pkg::ThrW'(66);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                esl_pkg::REG_LAYER_LEN: r_len <= pwdata[esl_pkg::LenW-1:0];
                esl_pkg::REG_THRESHOLD: r_thr <= pwdata[esl_pkg::ThrW-1:0];
                default: ;
            endcase
        end
    end

    esl_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (alu_req),
        .o_rsp  (alu_rsp)
    );

    esl_ram #(
        .Width(esl_pkg::CellW),
        .Depth(esl_pkg::MaxCells)
    ) u_cells (
        .i_clk    (i_clk),
        .i_wr_en  (ram_we),
        .i_wr_addr(ram_waddr),
        .i_wr_data(ram_wdata),
        .i_rd_addr(r_raddr),
        .o_rd_data(ram_rdata)
    );

    assign busy           = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_max_value    = r_out_max;
    assign o_max_position = r_out_idx;
    assign pready         = 1'b1;
    assign prdata = (paddr[2] == esl_pkg::REG_THRESHOLD) ? {16'd0, r_thr} : {19'd0, r_len};

endmodule

// ===== rtl/core/esl_ram.sv =====
`timescale 1ns / 1ps
module esl_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(Depth)-1:0] i_wr_addr,
    input  logic [Width-1:0]         i_wr_data,
    input  logic [$clog2(Depth)-1:0] i_rd_addr,
    output logic [Width-1:0]         o_rd_data
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/esl_alu.sv =====
`timescale 1ns / 1ps
// Shared iterative unit: restoring divide (one quotient bit a cycle) or integer
// square root (one root bit a cycle).
module esl_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esl_pkg::t_alu_req i_req,
    output esl_pkg::t_alu_rsp o_rsp
);

    typedef enum logic [1:0] {
        A_IDLE,
        A_DIV,
        A_SQRT
    } t_state;

    t_state                       r_state;
    logic [6:0]                   r_cnt;
    logic [esl_pkg::NumW-1:0]     r_num;
    logic [esl_pkg::DenW-1:0]     r_den;
    logic [esl_pkg::DenW:0]       r_rem;
    logic [esl_pkg::RadW-1:0]     r_rad;
    logic [esl_pkg::RootW+2:0]    r_srem;
    logic [esl_pkg::RootW-1:0]    r_root;
    logic                         r_done;

    logic [esl_pkg::DenW:0]    n_rem;
    logic                      n_qbit;
    logic [esl_pkg::RootW+2:0] n_srem;
    logic [esl_pkg::RootW+2:0] n_trial;

    // one divide step
    always_comb begin
        n_rem  = {r_rem[esl_pkg::DenW-1:0], r_num[esl_pkg::NumW-1]};
        n_qbit = (n_rem >= {1'b0, r_den});
        if (n_qbit) begin
            n_rem = n_rem - {1'b0, r_den};
        end
    end

    // one root step
    always_comb begin
        n_srem  = {r_srem[esl_pkg::RootW:0], r_rad[esl_pkg::RadW-1 -: 2]};
        n_trial = {1'b0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                A_IDLE: begin
                    if (i_req.go) begin
                        r_num  <= i_req.num;
                        r_den  <= i_req.den;
                        r_rem  <= '0;
                        r_rad  <= i_req.rad;
                        r_srem <= '0;
                        r_root <= '0;
                        if (i_req.op == esl_pkg::ALU_DIV) begin
                            r_cnt   <= 7'(esl_pkg::NumW - 1);
                            r_state <= A_DIV;
                        end else begin
                            r_cnt   <= 7'(esl_pkg::RootW - 1);
                            r_state <= A_SQRT;
                        end
                    end
                end
                A_DIV: begin
                    r_rem <= n_rem;
                    r_num <= {r_num[esl_pkg::NumW-2:0], n_qbit};
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                A_SQRT: begin
                    r_rad <= {r_rad[esl_pkg::RadW-3:0], 2'b00};
                    if (n_srem >= n_trial) begin
                        r_srem <= n_srem - n_trial;
                        r_root <= {r_root[esl_pkg::RootW-2:0], 1'b1};
                    end else begin
                        r_srem <= n_srem;
                        r_root <= {r_root[esl_pkg::RootW-2:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= A_IDLE;
                    end
                end
                default: r_state <= A_IDLE;
            endcase
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_num;
    assign o_rsp.root = r_root;

endmodule
